// ===== hdl/kfd_pkg.sv =====
// kfd_pkg: shared constants for the keyed FIFO with delete.
// Request codes, field widths and the default queue depth.
// No dependencies.
package kfd_pkg;

    localparam int KFD_DEPTH = 16;
    localparam int KEY_W     = 16;
    localparam int PAY_W     = 32;
    localparam int REQ_W     = 3;
    localparam int CNT_OUT_W = 5;

    // in beat: key_id, entry_payload
    localparam int S_DATA_W  = 48;
    // out beat: done_ok, hit, out_id, out_payload, count_now, is_empty
    localparam int M_DATA_W  = 56;

    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

endpackage

// ===== hdl/keyed_fifo_with_delete.sv =====
// keyed_fifo_with_delete: ordered key/payload queue held in one RAM.
// Depends on kfd_pkg.
//
// Records sit in RAM slots 0..count-1, head in slot 0. Append and clear go
// straight to the finish state, which posts the output beat. Search walks
// the RAM from the head, one slot per cycle through the single registered
// read port. Pop and remove find the record the same way, then slide every
// later record down one slot, a read and a write per cycle overlapped,
// unless the record was the last one. A new request is taken only once the
// previous one has finished; a finished result sits in the output register
// until it is taken, and the block waits for that before posting the next.
module keyed_fifo_with_delete #(
    parameter int DEPTH = kfd_pkg::KFD_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [15:0] key_id, [47:16] entry_payload
    input  logic [kfd_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [2:0] req_type
    input  logic [kfd_pkg::REQ_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] done_ok, [1] hit, [17:2] out_id, [49:18] out_payload,
    // [54:50] count_now, [55] is_empty
    output logic [kfd_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import kfd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_W + PAY_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    logic [EW-1:0] mem [DEPTH];

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_cmp_idx, n_cmp_idx;
    logic                r_pend, n_pend;
    logic [REQ_W-1:0]    r_req, n_req;
    logic [KEY_W-1:0]    r_key, n_key;
    logic                r_ok, n_ok;
    logic                r_hit, n_hit;
    logic [KEY_W-1:0]    r_rid, n_rid;
    logic [PAY_W-1:0]    r_rpay, n_rpay;
    logic [EW-1:0]       r_rdata;
    logic                r_out_vld, n_out_vld;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic [AW-1:0]       rd_addr;
    logic                issue;
    logic                match;
    logic [KEY_W-1:0]    rd_key;
    logic [31:0]         cnt_ext;
    logic [CW-1:0]       next_pos;

    assign rd_addr  = r_idx[AW-1:0];
    assign issue    = (r_idx < r_count);
    assign rd_key   = r_rdata[EW-1:PAY_W];
    assign match    = (r_req == REQ_POP) || (rd_key == r_key);
    assign next_pos = CW'(r_cmp_idx) + CW'(1);
    assign cnt_ext  = 32'(r_count);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_cmp_idx  = r_cmp_idx;
        n_pend     = r_pend;
        n_req      = r_req;
        n_key      = r_key;
        n_ok       = r_ok;
        n_hit      = r_hit;
        n_rid      = r_rid;
        n_rpay     = r_rpay;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = r_rdata;

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_req   = i_s_tuser;
                    n_key   = i_s_tdata[KEY_W-1:0];
                    n_ok    = 1'b0;
                    n_hit   = 1'b0;
                    n_rid   = '0;
                    n_rpay  = '0;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                    unique case (i_s_tuser)
                        REQ_APPEND: begin
                            if (r_count != CW'(DEPTH)) begin
                                wr_en   = 1'b1;
                                wr_data = {i_s_tdata[KEY_W-1:0],
                                           i_s_tdata[KEY_W+PAY_W-1:KEY_W]};
                                n_count = r_count + CW'(1);
                                n_ok    = 1'b1;
                            end
                        end
                        REQ_POP, REQ_SEARCH, REQ_REMOVE: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_CLEAR: begin
                            n_count = '0;
                            n_ok    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // read the next slot while comparing the one read last cycle
                n_pend = issue;
                if (issue) begin
                    n_idx     = r_idx + CW'(1);
                    n_cmp_idx = r_idx[AW-1:0];
                end
                if (r_pend) begin
                    if (match) begin
                        n_ok   = 1'b1;
                        n_hit  = (r_req != REQ_POP);
                        n_rid  = rd_key;
                        n_rpay = r_rdata[PAY_W-1:0];
                        if (r_req == REQ_SEARCH) begin
                            n_state = S_FIN;
                        end else if (next_pos < r_count) begin
                            n_idx   = next_pos;
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_FIN;
                        end
                    end else if (!issue) begin
                        n_state = S_FIN;
                    end
                end
            end

            S_SHIFT: begin
                // slot i+1 read last cycle lands in slot i; reads run ahead of writes
                n_pend = issue;
                if (issue) begin
                    n_idx     = r_idx + CW'(1);
                    n_cmp_idx = r_idx[AW-1:0];
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cmp_idx - AW'(1);
                    wr_data = r_rdata;
                    if (!issue) begin
                        n_count = r_count - CW'(1);
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {(r_count == '0), cnt_ext[CNT_OUT_W-1:0],
                                  r_rpay, r_rid, r_hit, r_ok};
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_req      <= n_req;
        r_key      <= n_key;
        r_ok       <= n_ok;
        r_hit      <= n_hit;
        r_rid      <= n_rid;
        r_rpay     <= n_rpay;
        r_out_data <= n_out_data;
    end

endmodule

// ===== hdl/kfd_checker.sv =====
// kfd_checker: port-level assertions for keyed_fifo_with_delete, bound to it.
// Depends on kfd_pkg and the top level's port list.
module kfd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [kfd_pkg::M_DATA_W-1:0] o_m_tdata
);
    import kfd_pkg::*;

    // a stalled out beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("out beat changed while stalled");

    // reset drops the out beat
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("out valid after reset");

    // a hit is always a success
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1] |-> o_m_tdata[0])
        else $error("hit without done_ok");

    // failed requests carry no record
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[49:2] == '0)
        else $error("record data on failed request");

endmodule

bind keyed_fifo_with_delete kfd_checker u_kfd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
